// ===== src/http_request_line_parser_top_macros.svh =====
// assertion helpers for the request line parser
`ifndef HTTP_REQUEST_LINE_PARSER_TOP_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define HRLP_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HRLP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/hrlp_pkg.sv =====
`default_nettype none
package hrlp_pkg;

  typedef struct packed {
    logic       start_of_request;
    logic [7:0] byte_in;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       last;
  } res_t;

  // results of one byte, in order, count of valid entries in cnt
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [2:0]       items;
  } group_t;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_GAP,
    PH_PATH,
    PH_QUERY,
    PH_PROTO,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic        first_seen;
    logic        slash_ok;
    logic        nul_seen;
    logic [15:0] name_count;
  } name_st_t;

  typedef struct packed {
    name_st_t s;
    logic     put;
  } emit_res_t;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_NAME   = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_REQ   = 3'd1;
  localparam logic [2:0] ST_BAD_METH  = 3'd2;
  localparam logic [2:0] ST_BAD_NAME  = 3'd3;
  localparam logic [2:0] ST_BAD_QUERY = 3'd4;

  localparam logic [1:0] DS_IDLE  = 2'd0;
  localparam logic [1:0] DS_PCT   = 2'd1;
  localparam logic [1:0] DS_DIGIT = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_LOWER = 8'h20;

  localparam logic [1:0]  METHOD_LEN  = 2'd3;
  localparam logic [15:0] LIMIT_RESET = 16'd1024;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  function automatic logic [7:0] get_char(input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = 8'h67;
      2'd1:    c = 8'h65;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = 8'h00;
    end
    return v[3:0];
  endfunction

  // one decoded path byte through the file-name tracker
  function automatic emit_res_t emit_step(input name_st_t s, input logic [7:0] d);
    emit_res_t r;
    r.s   = s;
    r.put = 1'b0;
    if (!s.first_seen) begin
      r.s.first_seen = 1'b1;
      r.s.slash_ok   = (d == CH_SLASH);
    end else if (!s.nul_seen && s.slash_ok) begin
      if (d == CH_NUL) begin
        r.s.nul_seen = 1'b1;
      end else begin
        if (s.name_count != COUNT_MAX) begin
          r.s.name_count = s.name_count + 16'd1;
        end
        r.put = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/hrlp_parser.sv =====
`default_nettype none
module hrlp_parser
  import hrlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire req_t        req,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  output group_t           grp
);

  phase_t      phase, phase_next, cur_phase;
  logic [1:0]  method_progress, method_progress_next, cur_progress;
  logic        method_bad, method_bad_next, cur_method_bad;
  logic [1:0]  decode_stage, decode_stage_next, cur_stage;
  logic [7:0]  held_digit, held_digit_next, cur_held;
  logic [15:0] query_count, query_count_next, cur_query;
  name_st_t    name_st, name_st_next, cur_name;
  logic [15:0] name_limit;
  logic [15:0] thr;
  logic [7:0]  b;
  logic        ws;
  logic        line_end;

  assign b        = req.byte_in;
  assign ws       = (b == CH_SPACE) || (b == CH_TAB);
  assign line_end = (b == CH_CR) || (b == CH_LF) || (b == CH_NUL);
  assign thr      = (name_limit == 16'd0) ? 16'd0 : name_limit - 16'd1;

  // start of request clears before the byte is parsed
  always_comb begin
    if (req.start_of_request) begin
      cur_phase      = PH_METHOD;
      cur_progress   = 2'd0;
      cur_method_bad = 1'b0;
      cur_stage      = DS_IDLE;
      cur_held       = 8'h00;
      cur_query      = 16'd0;
      cur_name       = '0;
    end else begin
      cur_phase      = phase;
      cur_progress   = method_progress;
      cur_method_bad = method_bad;
      cur_stage      = decode_stage;
      cur_held       = held_digit;
      cur_query      = query_count;
      cur_name       = name_st;
    end
  end

  always_comb begin
    phase_next = cur_phase;
    if (cur_phase != PH_DONE) begin
      if (line_end) begin
        phase_next = PH_DONE;
      end else begin
        unique case (cur_phase)
          PH_METHOD: begin
            if (ws) phase_next = PH_GAP;
          end
          PH_GAP: begin
            if (!ws) phase_next = (b == CH_QM) ? PH_QUERY : PH_PATH;
          end
          PH_PATH: begin
            if (ws) phase_next = PH_PROTO;
            else if (b == CH_QM) phase_next = PH_QUERY;
          end
          PH_QUERY: begin
            if (ws) phase_next = PH_PROTO;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    logic [7:0] ed [3];
    logic [2:0] een;
    logic [1:0] ec;
    logic [1:0] oc;
    logic       do_path;
    logic       do_flush;
    logic       pass_b;
    emit_res_t  er;
    name_st_t   ns;
    logic [2:0] st;

    ed[0] = 8'h00;
    ed[1] = 8'h00;
    ed[2] = 8'h00;
    een   = 3'b000;
    ec    = 2'd0;
    oc    = 2'd0;
    pass_b = 1'b0;
    er    = '0;
    st    = ST_OK;
    grp   = '0;

    method_progress_next = cur_progress;
    method_bad_next      = cur_method_bad;
    decode_stage_next    = cur_stage;
    held_digit_next      = cur_held;
    query_count_next     = cur_query;

    do_path  = 1'b0;
    do_flush = 1'b0;

    if (cur_phase != PH_DONE && !line_end) begin
      if (cur_phase == PH_GAP && !ws && b != CH_QM) do_path = 1'b1;
      if (cur_phase == PH_PATH && !ws && b != CH_QM) do_path = 1'b1;
      if (cur_phase == PH_PATH && (ws || b == CH_QM)) do_flush = 1'b1;

      if (cur_phase == PH_METHOD) begin
        if (ws) begin
          if (cur_progress != METHOD_LEN) method_bad_next = 1'b1;
        end else if (cur_progress < METHOD_LEN &&
                     (b | CH_LOWER) == get_char(cur_progress)) begin
          method_progress_next = cur_progress + 2'd1;
        end else begin
          method_bad_next = 1'b1;
        end
      end
    end

    if (do_flush) begin
      if (cur_stage != DS_IDLE) begin
        ed[ec] = CH_PCT; een[ec] = 1'b1; ec = ec + 2'd1;
      end
      if (cur_stage == DS_DIGIT) begin
        ed[ec] = cur_held; een[ec] = 1'b1; ec = ec + 2'd1;
      end
      decode_stage_next = DS_IDLE;
    end

    if (do_path) begin
      pass_b = 1'b1;
      case (cur_stage)
        DS_PCT: begin
          if (is_hex(b)) begin
            held_digit_next   = b;
            decode_stage_next = DS_DIGIT;
            pass_b            = 1'b0;
          end else begin
            ed[ec] = CH_PCT; een[ec] = 1'b1; ec = ec + 2'd1;
            decode_stage_next = DS_IDLE;
          end
        end
        DS_DIGIT: begin
          if (is_hex(b)) begin
            ed[ec] = {hex_val(cur_held), hex_val(b)}; een[ec] = 1'b1; ec = ec + 2'd1;
            decode_stage_next = DS_IDLE;
            pass_b            = 1'b0;
          end else begin
            ed[ec] = CH_PCT; een[ec] = 1'b1; ec = ec + 2'd1;
            ed[ec] = cur_held; een[ec] = 1'b1; ec = ec + 2'd1;
            decode_stage_next = DS_IDLE;
          end
        end
        default: ;
      endcase
      if (pass_b) begin
        if (b == CH_PCT) begin
          decode_stage_next = DS_PCT;
        end else begin
          ed[ec] = b; een[ec] = 1'b1; ec = ec + 2'd1;
        end
      end
    end

    ns = cur_name;
    for (int i = 0; i < 3; i++) begin
      if (een[i]) begin
        er = emit_step(ns, ed[i]);
        ns = er.s;
        if (er.put && !cur_method_bad) begin
          grp.items[oc] = '{kind: KIND_NAME, data_byte: ed[i], status: ST_OK, last: 1'b0};
          oc = oc + 2'd1;
        end
      end
    end
    name_st_next = ns;

    if (cur_phase == PH_QUERY && !line_end && !ws) begin
      if (cur_query != COUNT_MAX) query_count_next = cur_query + 16'd1;
      if (!cur_method_bad && cur_name.first_seen && cur_name.slash_ok) begin
        grp.items[oc] = '{kind: KIND_QUERY, data_byte: b, status: ST_OK, last: 1'b0};
        oc = oc + 2'd1;
      end
    end

    if (cur_phase != PH_DONE && line_end) begin
      if (cur_phase != PH_PROTO) begin
        st = ST_BAD_REQ;
      end else if (cur_method_bad) begin
        st = ST_BAD_METH;
      end else if (!cur_name.first_seen || !cur_name.slash_ok ||
                   cur_name.name_count >= thr) begin
        st = ST_BAD_NAME;
      end else if (cur_query >= thr) begin
        st = ST_BAD_QUERY;
      end else begin
        st = ST_OK;
      end
      grp.items[oc] = '{kind: KIND_STATUS, data_byte: 8'h00, status: st, last: 1'b1};
      oc = oc + 2'd1;
    end

    grp.cnt = oc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_METHOD;
      method_progress <= 2'd0;
      method_bad      <= 1'b0;
      decode_stage    <= DS_IDLE;
      held_digit      <= 8'h00;
      query_count     <= 16'd0;
      name_st         <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      method_progress <= method_progress_next;
      method_bad      <= method_bad_next;
      decode_stage    <= decode_stage_next;
      held_digit      <= held_digit_next;
      query_count     <= query_count_next;
      name_st         <= name_st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      name_limit <= cfg_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/hrlp_out_buf.sv =====
`default_nettype none
module hrlp_out_buf
  import hrlp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load,
  input  wire group_t grp,
  output logic        ready,
  output logic        res_valid,
  input  wire logic   res_ready,
  output res_t        res
);

  logic [1:0] cnt;
  logic [1:0] rd_idx;
  res_t [2:0] items;
  logic       pop;
  logic       last_item;

  assign res_valid = (cnt != 2'd0);
  assign res       = items[rd_idx];
  assign pop       = res_valid && res_ready;
  assign last_item = (rd_idx == cnt - 2'd1);
  // a new transaction may enter as the final item of the group leaves
  assign ready     = !res_valid || (pop && last_item);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      rd_idx <= 2'd0;
    end else if (load) begin
      cnt    <= grp.cnt;
      rd_idx <= 2'd0;
    end else if (pop) begin
      if (last_item) begin
        cnt    <= 2'd0;
        rd_idx <= 2'd0;
      end else begin
        rd_idx <= rd_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items <= grp.items;
    end
  end

endmodule
`default_nettype wire

// ===== src/http_request_line_parser_top.sv =====
// HTTP request line parser.
// req carries one byte of the request stream per transaction (req_valid / req_ready);
// start_of_request set on a byte clears the parser before that byte is parsed.
// res carries result items (res_valid / res_ready): decoded file-name bytes, raw query
// bytes, and one status item with last set when CR, LF or NUL ends the line.
// Bytes after the line end give nothing until the next start_of_request.
// Latency: the first item of a byte is on res the cycle after the byte is taken.
// A byte yields 0 to 3 items; they leave one per cycle from a three-entry result
// register, and the next byte is taken in the cycle the last of them leaves.
// Throughput is one byte per cycle while each byte gives at most one item and res is
// not stalled; a byte giving more items holds req until the last of them leaves.
// cfg_we writes name_limit from cfg_data at once; write it only while idle.
// When res_ready is low, the current item holds and req_ready drops until the
// transaction's items have all gone.
// Reset: parser state cleared, name_limit 1024, result register empty.
`default_nettype none
`include "http_request_line_parser_top_macros.svh"
module http_request_line_parser_top
  import hrlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  group_t grp;
  logic   accept;
  logic   res_pop;
  logic   res_is_byte;
  logic   clear_cr;

  assign accept      = req_valid && req_ready;
  assign res_pop     = res_valid && res_ready;
  assign res_is_byte = res_valid && (res.kind != KIND_STATUS);
  assign clear_cr    = accept && req.start_of_request && (req.byte_in == CH_CR);

  hrlp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .grp      (grp)
  );

  hrlp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .grp       (grp),
    .ready     (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  `HRLP_CHECK(a_empty_ready, !res_valid, req_ready, "empty result register not ready")
  `HRLP_CHECK(a_status_frees, res_pop && res.last, req_ready, "input blocked after status")
  `HRLP_CHECK(a_byte_fields, res_is_byte, res.status == ST_OK && !res.last, "byte item fields")
  `HRLP_CHECK_NEXT(a_clear_end, clear_cr, res_valid && res.last, "no status after line end")

endmodule
`default_nettype wire

// ===== test/http_request_line_parser_checker.sv =====
`timescale 1ns / 1ps
module http_request_line_parser_checker
  import hrlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  req_t        req,
  input  logic        res_valid,
  input  logic        res_ready,
  input  res_t        res,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          outstanding
);

  localparam logic [23:0] GET_WORD = "get";

  res_t        expected_items[$];
  res_t        want;
  int          mismatch_count = 0;
  int          byte_items;
  logic [15:0] name_limit;
  phase_t      phase;
  logic [1:0]  method_matched;
  logic        method_wrong;
  logic [1:0]  pct_stage;
  logic [7:0]  first_digit;
  logic [15:0] name_len;
  logic [15:0] query_len;
  logic        path_started;
  logic        leading_slash;
  logic        name_cut;

  task automatic clear_parser();
    phase          = PH_METHOD;
    method_matched = 2'd0;
    method_wrong   = 1'b0;
    pct_stage      = DS_IDLE;
    first_digit    = 8'h00;
    name_len       = 16'd0;
    query_len      = 16'd0;
    path_started   = 1'b0;
    leading_slash  = 1'b0;
    name_cut       = 1'b0;
  endtask

  // at most three items per transaction
  task automatic expect_item(input logic [1:0] kind, input logic [7:0] data,
                             input logic [2:0] st, input logic last);
    res_t item;
    if (byte_items < 3) begin
      item.kind      = kind;
      item.data_byte = data;
      item.status    = st;
      item.last      = last;
      expected_items.push_back(item);
      byte_items++;
    end
  endtask

  // {is hex digit, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, c[3:0]};
    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  task automatic take_decoded(input logic [7:0] d);
    if (!path_started) begin
      path_started  = 1'b1;
      leading_slash = (d == CH_SLASH);
    end else if (!name_cut && leading_slash) begin
      if (d == CH_NUL) begin
        name_cut = 1'b1;
      end else begin
        if (name_len != COUNT_MAX) name_len = name_len + 16'd1;
        if (!method_wrong) expect_item(KIND_NAME, d, ST_OK, 1'b0);
      end
    end
  endtask

  task automatic flush_escape();
    if (pct_stage != DS_IDLE) take_decoded(CH_PCT);
    if (pct_stage == DS_DIGIT) take_decoded(first_digit);
    pct_stage = DS_IDLE;
  endtask

  task automatic decode_path_byte(input logic [7:0] b);
    logic [4:0] lo;
    logic [4:0] hi;
    logic       used;
    lo   = hex_digit(b);
    hi   = hex_digit(first_digit);
    used = 1'b0;
    if (pct_stage == DS_PCT) begin
      if (lo[4]) begin
        first_digit = b;
        pct_stage   = DS_DIGIT;
        used        = 1'b1;
      end else begin
        take_decoded(CH_PCT);
        pct_stage = DS_IDLE;
      end
    end else if (pct_stage == DS_DIGIT) begin
      if (lo[4]) begin
        take_decoded({hi[3:0], lo[3:0]});
        used = 1'b1;
      end else begin
        take_decoded(CH_PCT);
        take_decoded(first_digit);
      end
      pct_stage = DS_IDLE;
    end
    if (!used) begin
      if (b == CH_PCT) pct_stage = DS_PCT;
      else take_decoded(b);
    end
  endtask

  function automatic logic [2:0] line_status();
    logic [15:0] thr;
    logic [2:0]  st;
    thr = (name_limit != 16'd0) ? name_limit - 16'd1 : 16'd0;
    if (phase != PH_PROTO) st = ST_BAD_REQ;
    else if (method_wrong) st = ST_BAD_METH;
    else if (!path_started || !leading_slash || name_len >= thr) st = ST_BAD_NAME;
    else if (query_len >= thr) st = ST_BAD_QUERY;
    else st = ST_OK;
    return st;
  endfunction

  task automatic parse_byte(input req_t r);
    logic [7:0] b;
    logic       ws;
    int         idx;
    b          = r.byte_in;
    ws         = (b == CH_SPACE || b == CH_TAB);
    byte_items = 0;
    if (r.start_of_request) clear_parser();
    if (phase == PH_DONE) begin
      // rest of the line is ignored
    end else if (b == CH_CR || b == CH_LF || b == CH_NUL) begin
      expect_item(KIND_STATUS, 8'h00, line_status(), 1'b1);
      phase = PH_DONE;
    end else begin
      case (phase)
        PH_METHOD: begin
          idx = 2 - int'(method_matched);
          if (ws) begin
            if (method_matched != METHOD_LEN) method_wrong = 1'b1;
            phase = PH_GAP;
          end else if (method_matched != METHOD_LEN &&
                       (b | CH_LOWER) == GET_WORD[8*idx +: 8]) begin
            method_matched = method_matched + 2'd1;
          end else begin
            method_wrong = 1'b1;
          end
        end
        PH_GAP: begin
          if (!ws) begin
            if (b == CH_QM) begin
              phase = PH_QUERY;
            end else begin
              phase = PH_PATH;
              decode_path_byte(b);
            end
          end
        end
        PH_PATH: begin
          if (ws) begin
            flush_escape();
            phase = PH_PROTO;
          end else if (b == CH_QM) begin
            flush_escape();
            phase = PH_QUERY;
          end else begin
            decode_path_byte(b);
          end
        end
        PH_QUERY: begin
          if (ws) begin
            phase = PH_PROTO;
          end else begin
            if (query_len != COUNT_MAX) query_len = query_len + 16'd1;
            if (!method_wrong && path_started && leading_slash)
              expect_item(KIND_QUERY, b, ST_OK, 1'b0);
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic report(input string field, input int want_v, input int got_v);
    mismatch_count++;
    $error("%s: expected %0d, actual %0d", field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      name_limit = LIMIT_RESET;
      clear_parser();
      expected_items.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (expected_items.size() == 0) begin
          mismatch_count++;
          $error("result with nothing pending: kind %0d data %0d status %0d last %0d",
                 res.kind, res.data_byte, res.status, res.last);
        end else begin
          want = expected_items.pop_front();
          if (want.kind !== res.kind) report("kind", want.kind, res.kind);
          if (want.data_byte !== res.data_byte)
            report("data_byte", want.data_byte, res.data_byte);
          if (want.status !== res.status) report("status", want.status, res.status);
          if (want.last !== res.last) report("last", want.last, res.last);
        end
      end
      if (req_valid && req_ready) parse_byte(req);
      if (cfg_we) name_limit = cfg_data;
    end
    outstanding <= expected_items.size();
    errors      <= mismatch_count;
  end

endmodule

// ===== test/tb_http_request_line_parser_top.sv =====
`timescale 1ns / 1ps
module tb_http_request_line_parser_top;
  import hrlp_pkg::*;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int PHASE_BYTES = 25;

  logic        clk;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req       = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_t        res;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_data  = '0;
  int          errors;
  int          outstanding;
  int          cycles     = 0;
  int          burst_left = 0;
  int          ready_mode = 0;
  int          mode_left  = 0;
  int          tick       = 0;

  http_request_line_parser_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  http_request_line_parser_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    tick <= tick + 1;
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(16, 160);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0:       res_ready <= 1'b1;
      1:       res_ready <= ($urandom_range(0, 3) != 0);
      2:       res_ready <= (tick % 3 == 0);
      default: res_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic send_byte(input logic sor, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_valid <= 1'b1;
    req       <= '{start_of_request: sor, byte_in: b};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic sor_first);
    for (int i = 0; i < s.len(); i++) send_byte(sor_first && i == 0, s[i]);
  endtask

  task automatic send_line(input string s, input logic [7:0] term);
    send_text(s, 1'b1);
    send_byte(s.len() == 0, term);
  endtask

  task automatic set_limit(input logic [15:0] v);
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  task automatic random_traffic(input int target);
    logic [7:0] line[$];
    string      head;
    logic       sor_first;
    int         done_bytes;
    int         n;
    logic [7:0] c;
    done_bytes = 0;
    while (done_bytes < target) begin
      line.delete();
      if ($urandom_range(0, 9) == 0) begin
        // noise, start marks anywhere
        n = $urandom_range(1, 8);
        repeat (n) send_byte($urandom_range(0, 7) == 0, 8'($urandom));
        done_bytes += n;
      end else begin
        case ($urandom_range(0, 7))
          0:       head = "POST";
          1:       head = "GE";
          2:       head = "GETS";
          default: head = "GET";
        endcase
        for (int i = 0; i < head.len(); i++)
          line.push_back($urandom_range(0, 1) ? head[i] : (head[i] | CH_LOWER));
        repeat ($urandom_range(1, 2)) line.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        if ($urandom_range(0, 6) != 0) line.push_back(CH_SLASH);
        n = $urandom_range(0, 8);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 5) == 0) begin
            line.push_back(CH_PCT);
            if ($urandom_range(0, 7) == 0) begin
              line.push_back("0");
              line.push_back("0");
            end else begin
              line.push_back(hex_char());
              line.push_back(($urandom_range(0, 3) != 0) ? hex_char() : "x");
            end
          end else begin
            case ($urandom_range(0, 9))
              0:       c = hex_char();
              1:       c = 8'($urandom);
              2:       c = CH_SLASH;
              3:       c = CH_PCT;
              default: c = 8'h61 + 8'($urandom_range(0, 25));
            endcase
            line.push_back(c);
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          line.push_back(CH_QM);
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 7))
              0:       c = "=";
              1:       c = "&";
              2:       c = 8'($urandom);
              3:       c = CH_QM;
              default: c = 8'h41 + 8'($urandom_range(0, 25));
            endcase
            line.push_back(c);
          end
        end
        if ($urandom_range(0, 7) != 0) begin
          line.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
          line.push_back("H");
          line.push_back("1");
        end
        case ($urandom_range(0, 5))
          0:       line.push_back(CH_NUL);
          1:       line.push_back(CH_LF);
          default: line.push_back(CH_CR);
        endcase
        n = line.size();
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 3)) line.push_back(8'($urandom));
        sor_first = ($urandom_range(0, 11) != 0);
        for (int i = 0; i < line.size(); i++) send_byte(sor_first && i == 0, line[i]);
        if (sor_first) done_bytes += n;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // default limit
    send_line("GET /a%41b?x=1&y HTTP", CH_CR);
    send_line("get /%2fz%7E HTTP", CH_LF);
    send_line("GeT\t/idx.htm\tH", CH_LF);
    send_line("POST /a?q H", CH_CR);
    send_line("GETX /a H", CH_CR);
    send_line("GE /a H", CH_CR);
    send_line("GET a H", CH_CR);
    send_line("GET /abc", CH_CR);
    send_line("GET", CH_CR);
    send_line("", CH_CR);
    send_line("GET /%4 H", CH_CR);
    send_line("GET /%zz H", CH_CR);
    send_line("GET /%4g?%4 H", CH_CR);
    send_line("GET /%?q H", CH_CR);
    send_line("GET /ab%00cd?q H", CH_CR);
    send_line("GET ?q H", CH_CR);
    send_line("GET %2fa H", CH_CR);
    send_line("GET   /a b   H", CH_LF);
    send_text("GET /", 1'b1);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h80);
    send_byte(1'b0, 8'h01);
    send_text(" H", 1'b0);
    send_byte(1'b0, CH_CR);
    send_line("GET /x", CH_NUL);
    send_text("GET /y H", 1'b0);
    send_text("GET /ab%4", 1'b1);
    send_line("GET /c H", CH_CR);
    random_traffic(PHASE_BYTES);

    // smallest legal limit
    set_limit(16'd2);
    send_line("GET / H", CH_CR);
    send_line("GET /?ab H", CH_CR);
    send_line("GET /a H", CH_CR);
    random_traffic(PHASE_BYTES);

    // zero limit rejects every name
    set_limit(16'd0);
    send_line("GET / H", CH_CR);
    send_line("GET /?a H", CH_CR);
    random_traffic(PHASE_BYTES);

    // largest limit
    set_limit(16'hFFFF);
    random_traffic(PHASE_BYTES);

    repeat (2) begin
      set_limit(16'($urandom_range(3, 12)));
      random_traffic(PHASE_BYTES);
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/hrlp_pkg.sv
src/hrlp_parser.sv
src/hrlp_out_buf.sv
src/http_request_line_parser_top.sv
test/http_request_line_parser_checker.sv
test/tb_http_request_line_parser_top.sv
